// ===== hw/rtl/ordered_value_list_engine_core_macros.svh =====
// assertion macros used by the checker file
`ifndef ORDERED_VALUE_LIST_ENGINE_CORE_MACROS_SVH
`define ORDERED_VALUE_LIST_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define OVLE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OVLE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ovle_pkg.sv =====
`default_nettype none

package ovle_pkg;

    localparam int unsigned CAPACITY_DEF = 16;
    localparam int unsigned OP_W         = 3;
    localparam int unsigned VAL_W        = 32;
    localparam int unsigned ST_W         = 3;
    localparam int unsigned CNT_W        = 5;
    localparam int unsigned S_DATA_W     = 72;
    localparam int unsigned M_DATA_W     = 40;

    typedef enum logic [OP_W-1:0] {
        OP_FRONT  = 3'd0,
        OP_BACK   = 3'd1,
        OP_BEFORE = 3'd2,
        OP_DELETE = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_ANCHOR = 3'd1,
        ST_FULL      = 3'd2,
        ST_NO_VALUE  = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_READ,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        M_SEARCH,
        M_INSERT,
        M_DELETE
    } mode_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_ITEM_TAIL,
        WR_ITEM_IDX,
        WR_CARRY_IDX,
        WR_RDATA_PREV
    } wr_sel_t;

    typedef struct packed {
        logic    load;
        logic    idx_clr;
        logic    idx_inc;
        logic    rd_en;
        wr_sel_t wr_sel;
        logic    carry_item;
        logic    carry_rdata;
        logic    count_inc;
        logic    count_dec;
        logic    out_load;
        logic    out_rdata;
        logic    out_last;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            count_zero;
        logic            full;
        logic            match;
        logic            at_end;
        logic            at_last;
        logic            out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ordered_value_list_engine_core.sv =====
// ordered list of up to CAPACITY signed 32-bit values, position 0 is the front
// input channel s_*: one request per item (add front, add back, insert before
// anchor, delete value, read all); s_tready is high only while no request is
// in progress
// result channel m_*: one item per request, or one item per entry for a
// read-all of a non-empty list; m_tlast marks the final item of a request
// add back and insert before anchor into an empty list: the item is written
// at the tail in the decode state; add front, insert before anchor, delete:
// the decode state leads into a walk of the list that reads one entry a cycle
// through the single registered read port of the list memory
// read-all: the entries in list order, one entry per cycle while the receiver
// takes them; a result waits in the output register while the next request
// is taken; a stalled receiver holds the output and pauses a read-all or the
// end of a request until the register frees
// reset empties the list and drops any pending result
`default_nettype none

module ordered_value_list_engine_core #(
    parameter int unsigned CAPACITY = ovle_pkg::CAPACITY_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // op[2:0], item_value[34:3], anchor_value[66:35], zero pad [71:67]
    input  wire logic [ovle_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // status[2:0], read_value[34:3], entry_count[39:35]
    output logic      [ovle_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                                 m_tlast
);

    ovle_pkg::cmd_t cmd;
    ovle_pkg::sts_t sts;

    ovle_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ovle_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/ovle_ctrl.sv =====
`default_nettype none

module ovle_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  ovle_pkg::sts_t     sts,
    output ovle_pkg::cmd_t     cmd
);

    ovle_pkg::state_t  state_reg, state_next;
    ovle_pkg::mode_t   mode_reg, mode_next;
    ovle_pkg::status_t status_reg, status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ovle_pkg::S_IDLE;
            mode_reg   <= ovle_pkg::M_SEARCH;
            status_reg <= ovle_pkg::ST_OK;
        end else begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            status_reg <= status_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        status_next = status_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        case (state_reg)
            ovle_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load    = 1'b1;
                    cmd.idx_clr = 1'b1;
                    cmd.rd_en   = 1'b1;
                    state_next  = ovle_pkg::S_DECODE;
                end
            end
            ovle_pkg::S_DECODE: begin
                status_next = ovle_pkg::ST_OK;
                if (sts.full && (sts.op inside {ovle_pkg::OP_FRONT, ovle_pkg::OP_BACK,
                                                ovle_pkg::OP_BEFORE})) begin
                    status_next = ovle_pkg::ST_FULL;
                    state_next  = ovle_pkg::S_FINISH;
                end else begin
                    case (sts.op)
                        ovle_pkg::OP_FRONT: begin
                            cmd.carry_item = 1'b1;
                            mode_next      = ovle_pkg::M_INSERT;
                            state_next     = ovle_pkg::S_WALK;
                        end
                        ovle_pkg::OP_BACK: begin
                            cmd.wr_sel    = ovle_pkg::WR_ITEM_TAIL;
                            cmd.count_inc = 1'b1;
                            state_next    = ovle_pkg::S_FINISH;
                        end
                        ovle_pkg::OP_BEFORE: begin
                            if (sts.count_zero) begin
                                cmd.wr_sel    = ovle_pkg::WR_ITEM_TAIL;
                                cmd.count_inc = 1'b1;
                                state_next    = ovle_pkg::S_FINISH;
                            end else begin
                                mode_next  = ovle_pkg::M_SEARCH;
                                state_next = ovle_pkg::S_WALK;
                            end
                        end
                        ovle_pkg::OP_DELETE: begin
                            if (sts.count_zero) begin
                                status_next = ovle_pkg::ST_NO_VALUE;
                                state_next  = ovle_pkg::S_FINISH;
                            end else begin
                                mode_next  = ovle_pkg::M_SEARCH;
                                state_next = ovle_pkg::S_WALK;
                            end
                        end
                        ovle_pkg::OP_READ: begin
                            if (sts.count_zero) begin
                                status_next = ovle_pkg::ST_EMPTY;
                                state_next  = ovle_pkg::S_FINISH;
                            end else begin
                                state_next = ovle_pkg::S_READ;
                            end
                        end
                        default: begin
                            state_next = ovle_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            ovle_pkg::S_WALK: begin
                case (mode_reg)
                    ovle_pkg::M_SEARCH: begin
                        if (sts.at_end) begin
                            status_next = (sts.op == ovle_pkg::OP_BEFORE) ?
                                          ovle_pkg::ST_NO_ANCHOR : ovle_pkg::ST_NO_VALUE;
                            state_next  = ovle_pkg::S_FINISH;
                        end else if (sts.match) begin
                            if (sts.op == ovle_pkg::OP_BEFORE) begin
                                cmd.wr_sel      = ovle_pkg::WR_ITEM_IDX;
                                cmd.carry_rdata = 1'b1;
                                cmd.idx_inc     = 1'b1;
                                cmd.rd_en       = 1'b1;
                                mode_next       = ovle_pkg::M_INSERT;
                            end else if (sts.at_last) begin
                                cmd.count_dec = 1'b1;
                                state_next    = ovle_pkg::S_FINISH;
                            end else begin
                                cmd.idx_inc = 1'b1;
                                cmd.rd_en   = 1'b1;
                                mode_next   = ovle_pkg::M_DELETE;
                            end
                        end else begin
                            cmd.idx_inc = 1'b1;
                            cmd.rd_en   = 1'b1;
                        end
                    end
                    ovle_pkg::M_INSERT: begin
                        cmd.wr_sel = ovle_pkg::WR_CARRY_IDX;
                        if (sts.at_end) begin
                            cmd.count_inc = 1'b1;
                            state_next    = ovle_pkg::S_FINISH;
                        end else begin
                            cmd.carry_rdata = 1'b1;
                            cmd.idx_inc     = 1'b1;
                            cmd.rd_en       = 1'b1;
                        end
                    end
                    ovle_pkg::M_DELETE: begin
                        cmd.wr_sel = ovle_pkg::WR_RDATA_PREV;
                        if (sts.at_last) begin
                            cmd.count_dec = 1'b1;
                            state_next    = ovle_pkg::S_FINISH;
                        end else begin
                            cmd.idx_inc = 1'b1;
                            cmd.rd_en   = 1'b1;
                        end
                    end
                    default: begin
                        state_next = ovle_pkg::S_FINISH;
                    end
                endcase
            end
            ovle_pkg::S_READ: begin
                if (sts.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_rdata  = 1'b1;
                    cmd.out_last   = sts.at_last;
                    cmd.out_status = ovle_pkg::ST_OK;
                    if (sts.at_last) begin
                        state_next = ovle_pkg::S_IDLE;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        cmd.rd_en   = 1'b1;
                    end
                end
            end
            ovle_pkg::S_FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_last   = 1'b1;
                    cmd.out_status = status_reg;
                    state_next     = ovle_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = ovle_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ovle_dp.sv =====
`default_nettype none

module ovle_dp #(
    parameter int unsigned CAPACITY = ovle_pkg::CAPACITY_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [ovle_pkg::S_DATA_W-1:0]   s_tdata,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic      [ovle_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                                 m_tlast,
    input  ovle_pkg::cmd_t                       cmd,
    output ovle_pkg::sts_t                       sts
);

    localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW    = $clog2(CAPACITY + 1);
    localparam int unsigned DEPTH = 1 << AW;
    localparam int unsigned VW    = ovle_pkg::VAL_W;

    logic [VW-1:0] mem [DEPTH];

    logic [ovle_pkg::OP_W-1:0]  op_reg;
    logic signed [VW-1:0]       item_reg;
    logic signed [VW-1:0]       anchor_reg;
    logic [VW-1:0]              rdata_reg;
    logic [VW-1:0]              carry_reg;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              count_reg;

    logic                       out_valid_reg;
    logic [ovle_pkg::ST_W-1:0]  out_status_reg;
    logic [VW-1:0]              out_value_reg;
    logic [ovle_pkg::CNT_W-1:0] out_count_reg;
    logic                       out_last_reg;

    logic [CW-1:0]              idx_prev;
    logic [VW-1:0]              key;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [VW-1:0]              wr_data;

    always_comb begin
        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.idx_inc) begin
            idx_next = idx_reg + CW'(1);
        end else begin
            idx_next = idx_reg;
        end
    end

    assign idx_prev = idx_reg - CW'(1);
    assign key      = (op_reg == ovle_pkg::OP_DELETE) ? item_reg : anchor_reg;

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = idx_reg[AW-1:0];
        wr_data = carry_reg;
        case (cmd.wr_sel)
            ovle_pkg::WR_ITEM_TAIL: begin
                wr_addr = count_reg[AW-1:0];
                wr_data = item_reg;
            end
            ovle_pkg::WR_ITEM_IDX: begin
                wr_data = item_reg;
            end
            ovle_pkg::WR_CARRY_IDX: begin
                wr_data = carry_reg;
            end
            ovle_pkg::WR_RDATA_PREV: begin
                wr_addr = idx_prev[AW-1:0];
                wr_data = rdata_reg;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    // list storage, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[idx_next[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= s_tdata[2:0];
            item_reg   <= s_tdata[34:3];
            anchor_reg <= s_tdata[66:35];
        end
        if (cmd.carry_item) begin
            carry_reg <= item_reg;
        end else if (cmd.carry_rdata) begin
            carry_reg <= rdata_reg;
        end
        if (cmd.out_load) begin
            out_status_reg <= cmd.out_status;
            out_value_reg  <= cmd.out_rdata ? rdata_reg : '0;
            out_count_reg  <= ovle_pkg::CNT_W'(count_reg);
            out_last_reg   <= cmd.out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (cmd.count_inc) begin
                count_reg <= count_reg + CW'(1);
            end else if (cmd.count_dec) begin
                count_reg <= count_reg - CW'(1);
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.op         = op_reg;
    assign sts.count_zero = (count_reg == '0);
    assign sts.full       = (count_reg == CW'(CAPACITY));
    assign sts.match      = (rdata_reg == key);
    assign sts.at_end     = (idx_reg == count_reg);
    assign sts.at_last    = (idx_reg == CW'(count_reg - CW'(1)));
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_value_reg, out_status_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ovle_chk.sv =====
`default_nettype none
`include "ordered_value_list_engine_core_macros.svh"

module ovle_chk #(
    parameter int unsigned CAPACITY = ovle_pkg::CAPACITY_DEF
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [ovle_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);

    `OVLE_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    `OVLE_ASSERT_NOW(a_mid_ok, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[2:0] == ovle_pkg::ST_OK, "non-final item without ok status")

    `OVLE_ASSERT_NOW(a_err_zero, aclk, aresetn, m_tvalid && (m_tdata[2:0] != ovle_pkg::ST_OK), m_tdata[34:3] == '0, "error item carries a value")

    `OVLE_ASSERT_NOW(a_count_max, aclk, aresetn, m_tvalid, (CAPACITY > 31) || (int'(m_tdata[39:35]) <= CAPACITY), "entry count above capacity")

endmodule

bind ordered_value_list_engine_core ovle_chk #(
    .CAPACITY (CAPACITY)
) u_ovle_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
